FILE: design/iir2_lookahead_fixed_filter_macros.svh
// Assertion macros for the look-ahead IIR filter checker.
// Included by the checker file only; no other dependencies.
`ifndef IIR2_LOOKAHEAD_FIXED_FILTER_MACROS_SVH
`define IIR2_LOOKAHEAD_FIXED_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIR2LA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIR2LA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/iir2la_pkg.sv
// Shared sizes, register indexes and the saturation helper for the IIR filter.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package iir2la_pkg;

  localparam int DATA_BITS      = 9;
  localparam int PRODUCT_BITS   = 17;
  localparam int PRODUCT_SHIFT  = 10;
  localparam int SUM_BITS       = 7;
  localparam int FIRST_SUM_BITS = 10;
  localparam int COEF_BITS      = 8;
  localparam int CFG_ADDR_BITS  = 3;

  // multiplier operand: wide enough for both the sample and w
  localparam int OPND_BITS  = (DATA_BITS > FIRST_SUM_BITS) ? DATA_BITS : FIRST_SUM_BITS;
  localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
  // working width for sums and clip compares, covers every range above
  localparam int CALC_BITS  = 34;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_C0 = 3'd3,
    REG_COEF_C1 = 3'd4,
    REG_COEF_C2 = 3'd5
  } cfg_reg_t;

  localparam logic signed [COEF_BITS-1:0] RST_COEF_B0 = 8'sd52;
  localparam logic signed [COEF_BITS-1:0] RST_COEF_B1 = 8'sd105;
  localparam logic signed [COEF_BITS-1:0] RST_COEF_B2 = 8'sd52;
  localparam logic signed [COEF_BITS-1:0] RST_COEF_C0 = 8'sd95;
  localparam logic signed [COEF_BITS-1:0] RST_COEF_C1 = -8'sd16;
  localparam logic signed [COEF_BITS-1:0] RST_COEF_C2 = -8'sd19;

  typedef struct packed {
    logic signed [CALC_BITS-1:0] val;
    logic                        clip;
  } sat_res_t;

  // Clamp v to a signed range of the given width; clip flags a clamp.
  function automatic sat_res_t sat_to(input logic signed [CALC_BITS-1:0] v,
                                      input int unsigned bits);
    logic signed [CALC_BITS-1:0] maxv;
    logic signed [CALC_BITS-1:0] minv;
    sat_res_t r;
    maxv = (CALC_BITS'(1) << (bits - 1)) - CALC_BITS'(1);
    minv = ~maxv;
    r.val  = v;
    r.clip = 1'b0;
    if (v > maxv) begin
      r.val  = maxv;
      r.clip = 1'b1;
    end else if (v < minv) begin
      r.val  = minv;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/iir2la_prod.sv
// One coefficient product: multiply, clamp, arithmetic shift, clamp again.
// Depends on iir2la_pkg.
`default_nettype none

module iir2la_prod (
  input  wire logic signed [iir2la_pkg::COEF_BITS-1:0] coef,
  input  wire logic signed [iir2la_pkg::OPND_BITS-1:0] opnd,
  output logic signed [iir2la_pkg::SUM_BITS-1:0]       prod,
  output logic                                         clip
);

  logic signed [iir2la_pkg::COEF_BITS+iir2la_pkg::OPND_BITS-1:0] mult;
  logic signed [iir2la_pkg::CALC_BITS-1:0]                       shifted;
  iir2la_pkg::sat_res_t                                          full_sat;
  iir2la_pkg::sat_res_t                                          out_sat;

  always_comb begin
    mult     = coef * opnd;
    full_sat = iir2la_pkg::sat_to(iir2la_pkg::CALC_BITS'(mult),
                                  iir2la_pkg::PRODUCT_BITS);
    // floor shift on a signed value
    shifted  = full_sat.val >>> iir2la_pkg::PRODUCT_SHIFT;
    out_sat  = iir2la_pkg::sat_to(shifted, iir2la_pkg::SUM_BITS);
    prod     = iir2la_pkg::SUM_BITS'(out_sat.val);
    clip     = full_sat.clip | out_sat.clip;
  end

endmodule

`default_nettype wire

FILE: design/iir2_lookahead_fixed_filter.sv
// Second-order fixed-point IIR filter (direct form II, one-step look-ahead,
// retimed). Takes one signed 9-bit sample per item and returns one filtered
// 9-bit sample plus an overflow flag per item. Throughput is one item per clock
// while the skid register is empty: all arithmetic for an item (four saturating
// sums and six coefficient products of 8 x 10 bits) runs in a single registered
// pass from the state registers and the input port to the result register, so
// the next sample can be taken in the following cycle. The result side is a
// two-entry stage (output register plus skid register), so input keeps flowing
// for one item while a result waits for out_tready.
// Coefficients come in over the cfg_ port (index 0..5: b0, b1, b2, c0, c1, c2,
// low 8 bits taken as signed); indexes 6 and 7 are ignored. Write them only
// while no item is in flight. Right after reset the first two results reflect
// the cleared product pipeline.
// Depends on iir2la_pkg and iir2la_prod.
`default_nettype none

module iir2_lookahead_fixed_filter (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // input stream
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [iir2la_pkg::TDATA_BITS-1:0]       in_tdata,   // [8:0] sample_in
  // result stream
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic [iir2la_pkg::TDATA_BITS-1:0]            out_tdata,  // [8:0] sample_out
  output logic [0:0]                                   out_tuser,  // [0] overflow
  // coefficient writes
  input  wire logic                                    cfg_wr_en,
  input  wire logic [iir2la_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [iir2la_pkg::COEF_BITS-1:0]        cfg_wdata
);

  localparam int SB = iir2la_pkg::SUM_BITS;
  localparam int CB = iir2la_pkg::CALC_BITS;
  localparam int WB = iir2la_pkg::FIRST_SUM_BITS;
  localparam int DB = iir2la_pkg::DATA_BITS;
  localparam int KB = iir2la_pkg::COEF_BITS;
  localparam int OB = iir2la_pkg::OPND_BITS;

  // ---------------------------------------------------------------- coefs
  logic signed [KB-1:0] coef_b0_r, coef_b1_r, coef_b2_r;
  logic signed [KB-1:0] coef_c0_r, coef_c1_r, coef_c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= iir2la_pkg::RST_COEF_B0;
      coef_b1_r <= iir2la_pkg::RST_COEF_B1;
      coef_b2_r <= iir2la_pkg::RST_COEF_B2;
      coef_c0_r <= iir2la_pkg::RST_COEF_C0;
      coef_c1_r <= iir2la_pkg::RST_COEF_C1;
      coef_c2_r <= iir2la_pkg::RST_COEF_C2;
    end else if (cfg_wr_en) begin
      case (iir2la_pkg::cfg_reg_t'(cfg_addr))
        iir2la_pkg::REG_COEF_B0: coef_b0_r <= cfg_wdata;
        iir2la_pkg::REG_COEF_B1: coef_b1_r <= cfg_wdata;
        iir2la_pkg::REG_COEF_B2: coef_b2_r <= cfg_wdata;
        iir2la_pkg::REG_COEF_C0: coef_c0_r <= cfg_wdata;
        iir2la_pkg::REG_COEF_C1: coef_c1_r <= cfg_wdata;
        iir2la_pkg::REG_COEF_C2: coef_c2_r <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  logic signed [WB-1:0] w_d1_r, w_d2_r;
  logic signed [SB-1:0] prod_c0_r, prod_c1_r, prod_b0_r, prod_b1_r;
  logic signed [SB-1:0] prod_c2_l0_r, prod_c2_l1_r;
  logic signed [SB-1:0] prod_b2_l0_r, prod_b2_l1_r;

  logic in_acc;
  assign in_acc = in_tvalid & in_tready;

  logic signed [DB-1:0] x;
  assign x = signed'(in_tdata[DB-1:0]);

  // ------------------------------------------------------- output sums
  iir2la_pkg::sat_res_t fb, w_res, ff, y_res;
  logic signed [WB-1:0] w_nxt;
  logic signed [DB-1:0] y_nxt;

  always_comb begin
    fb    = iir2la_pkg::sat_to(CB'(prod_c1_r) + CB'(prod_c2_l1_r), SB);
    w_res = iir2la_pkg::sat_to((CB'(prod_c0_r) <<< 2) + CB'(x) + (fb.val <<< 2), WB);
    ff    = iir2la_pkg::sat_to(CB'(prod_b1_r) + CB'(prod_b2_l1_r), SB);
    y_res = iir2la_pkg::sat_to((CB'(prod_b0_r) + ff.val) <<< 2, DB);
    w_nxt = WB'(w_res.val);
    y_nxt = DB'(y_res.val);
  end

  // ------------------------------------------------- products for next step
  logic signed [SB-1:0] pc0, pc1, pc2, pb0, pb1, pb2;
  logic [5:0]           prod_clip;

  iir2la_prod u_pc0 (.coef(coef_c0_r), .opnd(OB'(x)),      .prod(pc0), .clip(prod_clip[0]));
  iir2la_prod u_pc1 (.coef(coef_c1_r), .opnd(OB'(w_d1_r)), .prod(pc1), .clip(prod_clip[1]));
  iir2la_prod u_pc2 (.coef(coef_c2_r), .opnd(OB'(w_d1_r)), .prod(pc2), .clip(prod_clip[2]));
  iir2la_prod u_pb0 (.coef(coef_b0_r), .opnd(OB'(w_d1_r)), .prod(pb0), .clip(prod_clip[3]));
  iir2la_prod u_pb1 (.coef(coef_b1_r), .opnd(OB'(w_d2_r)), .prod(pb1), .clip(prod_clip[4]));
  iir2la_prod u_pb2 (.coef(coef_b2_r), .opnd(OB'(w_d2_r)), .prod(pb2), .clip(prod_clip[5]));

  logic ovf_nxt;
  assign ovf_nxt = fb.clip | w_res.clip | ff.clip | y_res.clip | (|prod_clip);

  // filter state advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_d1_r       <= '0;
      w_d2_r       <= '0;
      prod_c0_r    <= '0;
      prod_c1_r    <= '0;
      prod_b0_r    <= '0;
      prod_b1_r    <= '0;
      prod_c2_l0_r <= '0;
      prod_c2_l1_r <= '0;
      prod_b2_l0_r <= '0;
      prod_b2_l1_r <= '0;
    end else if (in_acc) begin
      w_d2_r       <= w_d1_r;
      w_d1_r       <= w_nxt;
      prod_c0_r    <= pc0;
      prod_c1_r    <= pc1;
      prod_b0_r    <= pb0;
      prod_b1_r    <= pb1;
      prod_c2_l1_r <= prod_c2_l0_r;
      prod_c2_l0_r <= pc2;
      prod_b2_l1_r <= prod_b2_l0_r;
      prod_b2_l0_r <= pb2;
    end
  end

  // ------------------------------------------ result register + skid entry
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic signed [DB-1:0] out_y_r, out_y_nxt, skid_y_r, skid_y_nxt;
  logic                 out_ovf_r, out_ovf_nxt, skid_ovf_r, skid_ovf_nxt;

  assign in_tready = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_y_nxt      = out_y_r;
    out_ovf_nxt    = out_ovf_r;
    skid_valid_nxt = skid_valid_r;
    skid_y_nxt     = skid_y_r;
    skid_ovf_nxt   = skid_ovf_r;
    if (skid_valid_r) begin
      // no new item while the skid entry is full; drain it on a take
      if (out_tready) begin
        out_y_nxt      = skid_y_r;
        out_ovf_nxt    = skid_ovf_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_tready) begin
        out_valid_nxt = 1'b1;
        out_y_nxt     = y_nxt;
        out_ovf_nxt   = ovf_nxt;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_y_nxt     = y_nxt;
        skid_ovf_nxt   = ovf_nxt;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_y_r    <= out_y_nxt;
    out_ovf_r  <= out_ovf_nxt;
    skid_y_r   <= skid_y_nxt;
    skid_ovf_r <= skid_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = iir2la_pkg::TDATA_BITS'(unsigned'(out_y_r));
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

FILE: design/iir2la_checker.sv
// Port-level checks for the look-ahead IIR filter, bound to the top level.
// Depends on iir2la_pkg and iir2_lookahead_fixed_filter_macros.svh.
`default_nettype none
`include "iir2_lookahead_fixed_filter_macros.svh"

module iir2la_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [iir2la_pkg::TDATA_BITS-1:0] out_tdata,
  input wire logic [0:0]                        out_tuser
);

  // a stalled result holds
  `IIR2LA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // input back-pressure only when the result register is occupied
  `IIR2LA_ASSERT_NOW(a_ready_low_full, !in_tready, out_tvalid, "input stalled with empty result")

  // y is four times a sum unless clamped, so low bits set means a clip
  `IIR2LA_ASSERT_NOW(a_clip_flag, out_tvalid && out_tdata[1:0] != 2'b00, out_tuser[0], "clamped output without overflow")

  // padding above the sample stays zero
  `IIR2LA_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[iir2la_pkg::TDATA_BITS-1:iir2la_pkg::DATA_BITS] == '0, "nonzero tdata padding")

endmodule

bind iir2_lookahead_fixed_filter iir2la_checker u_iir2la_checker (.*);

`default_nettype wire

FILE: tb/iir2_lookahead_fixed_filter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the look-ahead second-order IIR filter: a bit-exact filter
// predictor in a small scoreboard class, plus stream and coefficient drivers.
// Depends on iir2la_pkg and the iir2_lookahead_fixed_filter RTL.

import iir2la_pkg::*;

// Tracks the filter state, predicts one output per accepted sample, checks results.
class iir2_response_tracker;
  typedef struct packed {
    logic [DATA_BITS-1:0] out_sample;
    logic                 ovf;
  } filt_out_t;

  logic signed [COEF_BITS-1:0]      coef [0:5];
  logic signed [FIRST_SUM_BITS-1:0] w_d1, w_d2;
  logic signed [SUM_BITS-1:0]       c0_q, c1_q, b0_q, b1_q;
  logic signed [SUM_BITS-1:0]       c2_line [0:1];
  logic signed [SUM_BITS-1:0]       b2_line [0:1];
  filt_out_t expected_q [$];
  bit step_clip;
  int mismatches, checked, clipped;

  function new();
    coef[REG_COEF_B0] = RST_COEF_B0;
    coef[REG_COEF_B1] = RST_COEF_B1;
    coef[REG_COEF_B2] = RST_COEF_B2;
    coef[REG_COEF_C0] = RST_COEF_C0;
    coef[REG_COEF_C1] = RST_COEF_C1;
    coef[REG_COEF_C2] = RST_COEF_C2;
    w_d1 = '0;
    w_d2 = '0;
    c0_q = '0;
    c1_q = '0;
    b0_q = '0;
    b1_q = '0;
    c2_line[0] = '0;
    c2_line[1] = '0;
    b2_line[0] = '0;
    b2_line[1] = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // signed clamp to 'bits', remembers any clip in this step
  function longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) begin
      step_clip = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      step_clip = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  // clamp the full product, floor-shift, clamp again to the sum width
  function longint coef_product(logic signed [COEF_BITS-1:0] c, longint opnd);
    longint p;
    p = clamp(longint'(c) * opnd, PRODUCT_BITS);
    return clamp(p >>> PRODUCT_SHIFT, SUM_BITS);
  endfunction

  function void write_coef(logic [CFG_ADDR_BITS-1:0] idx, logic [COEF_BITS-1:0] v);
    if (idx <= REG_COEF_C2)
      coef[idx] = $signed(v);
  endfunction

  function void note_sample(logic [DATA_BITS-1:0] raw);
    longint x, fb, w, ff, y, pc0, pc1, pc2, pb0, pb1, pb2;
    filt_out_t e;
    step_clip = 1'b0;
    x  = longint'($signed(raw));
    // output side uses only the registered products
    fb = clamp(longint'(c1_q) + longint'(c2_line[1]), SUM_BITS);
    w  = clamp(4 * longint'(c0_q) + x + 4 * fb, FIRST_SUM_BITS);
    ff = clamp(longint'(b1_q) + longint'(b2_line[1]), SUM_BITS);
    y  = clamp(4 * (longint'(b0_q) + ff), DATA_BITS);
    // products for later steps; they count toward this step's flag
    pc0 = coef_product(coef[REG_COEF_C0], x);
    pc1 = coef_product(coef[REG_COEF_C1], longint'(w_d1));
    pc2 = coef_product(coef[REG_COEF_C2], longint'(w_d1));
    pb0 = coef_product(coef[REG_COEF_B0], longint'(w_d1));
    pb1 = coef_product(coef[REG_COEF_B1], longint'(w_d2));
    pb2 = coef_product(coef[REG_COEF_B2], longint'(w_d2));
    c2_line[1] = c2_line[0];
    b2_line[1] = b2_line[0];
    c0_q       = SUM_BITS'(pc0);
    c1_q       = SUM_BITS'(pc1);
    c2_line[0] = SUM_BITS'(pc2);
    b0_q       = SUM_BITS'(pb0);
    b1_q       = SUM_BITS'(pb1);
    b2_line[0] = SUM_BITS'(pb2);
    w_d2 = w_d1;
    w_d1 = FIRST_SUM_BITS'(w);
    e.out_sample = DATA_BITS'(y);
    e.ovf        = step_clip;
    expected_q.push_back(e);
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [DATA_BITS-1:0] got_y, logic got_ovf);
    filt_out_t e;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result y=%0d ovf=%0b with no item pending",
                                $signed(got_y), got_ovf));
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (e.ovf)
      clipped++;
    if (got_y !== e.out_sample)
      report_mismatch($sformatf("result %0d sample_out %0d, expected %0d", checked,
                                $signed(got_y), $signed(e.out_sample)));
    if (got_ovf !== e.ovf)
      report_mismatch($sformatf("result %0d overflow %0b, expected %0b", checked,
                                got_ovf, e.ovf));
  endtask
endclass

module iir2_lookahead_fixed_filter_test;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 130;
  localparam int SETTLE_CYCLES = 4;       // idle margin for the output register plus the skid entry

  // cfg indexes past the six coefficients; the block must ignore them
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [DATA_BITS-1:0] SAMPLE_MAX = 9'h0ff;
  localparam logic [DATA_BITS-1:0] SAMPLE_MIN = 9'h100;
  localparam logic [COEF_BITS-1:0] COEF_MAX   = 8'h7f;
  localparam logic [COEF_BITS-1:0] COEF_MIN   = 8'h80;

  localparam logic [COEF_BITS-1:0] RESET_COEFS [0:5] = '{RST_COEF_B0, RST_COEF_B1,
    RST_COEF_B2, RST_COEF_C0, RST_COEF_C1, RST_COEF_C2};

  // right after reset: zero, both extremes in runs, +-1 and the mid codes
  localparam logic [DATA_BITS-1:0] RESET_PROBE [0:11] = '{9'h000, 9'h000, 9'h0ff, 9'h0ff,
    9'h0ff, 9'h100, 9'h100, 9'h100, 9'h001, 9'h1ff, 9'h080, 9'h180};
  // with every coefficient at its minimum: long extreme runs push w and the products
  // into saturation
  localparam logic [DATA_BITS-1:0] CLIP_PROBE [0:9] = '{9'h100, 9'h100, 9'h100, 9'h100,
    9'h100, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff};

  typedef enum int {
    SET_RANDOM, SET_MAX, SET_MIN, SET_RESET, SET_GENTLE, SET_MIXED
  } coef_set_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [TDATA_BITS-1:0]      in_tdata   = '0;   // [8:0] sample_in
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [TDATA_BITS-1:0]      out_tdata;         // [8:0] sample_out
  logic [0:0]                 out_tuser;         // [0] overflow
  logic                       cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   cfg_addr   = '0;
  logic [COEF_BITS-1:0]       cfg_wdata  = '0;

  bit                   feed_gaps    = 1'b0;  // sender idles in bursts
  bit                   drain_stalls = 1'b0;  // receiver stalls in bursts
  int                   stall_left   = 0;
  int                   cycle_count  = 0;
  int                   settings_used = 0;
  int                   items_sent   = 0;
  logic [DATA_BITS-1:0] last_sample  = '0;

  iir2_response_tracker tracker = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  iir2_lookahead_fixed_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Result side: tready mostly high, dropped at random while enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (drain_stalls && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Handshake monitor. Values read here are the ones the block saw at this edge.
  // Results are checked before the new item is noted; every result is registered.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_result(out_tdata[DATA_BITS-1:0], out_tuser[0]);
      if (in_tvalid && in_tready)
        tracker.note_sample(in_tdata[DATA_BITS-1:0]);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending());
      $display("iir2_lookahead_fixed_filter_test NOT OK");
      $finish;
    end
  end

  // Present one sample and hold it until accepted. tvalid stays high on return so
  // back-to-back items need no second assignment in the same step.
  task automatic send_sample(logic [DATA_BITS-1:0] s);
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_BITS'(s);
    do @(posedge clk); while (!in_tready);
    last_sample = s;
    items_sent++;
  endtask

  // Stop sending and wait until every expected result is back, then let the pipe settle.
  // The first edge makes sure the monitor has noted the last accepted item.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the write lands at the next edge. cfg_wr_en is left high
  // so a following write goes out back to back.
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [COEF_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.write_coef(idx, v);
  endtask

  task automatic load_coefs(coef_set_t kind);
    logic [COEF_BITS-1:0] v;
    settings_used++;
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, COEF_BITS'($urandom));
    for (int r = REG_COEF_B0; r <= REG_COEF_C2; r++) begin
      case (kind)
        SET_RANDOM: v = COEF_BITS'($urandom);
        SET_MAX:    v = COEF_MAX;
        SET_MIN:    v = COEF_MIN;
        SET_RESET:  v = RESET_COEFS[CFG_ADDR_BITS'(r)];
        SET_GENTLE: v = COEF_BITS'($urandom_range(0, 40) - 20);
        default: begin
          case ($urandom_range(0, 3))
            0:       v = COEF_MIN;
            1:       v = COEF_MAX;
            2:       v = '0;
            default: v = COEF_BITS'($urandom);
          endcase
        end
      endcase
      write_reg(CFG_ADDR_BITS'(r), v);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Random sample mix: full range, small signals, extremes, and repeats that build
  // up constant runs (steady state and sustained saturation).
  function automatic logic [DATA_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_BITS'($urandom);
      4, 5:       return DATA_BITS'($urandom_range(0, 32) - 16);
      6:          return SAMPLE_MAX;
      7:          return SAMPLE_MIN;
      default:    return last_sample;
    endcase
  endfunction

  initial begin
    bit quiet;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset coefficients, first outputs come from the cleared pipeline
    feed_gaps = 1'b1;
    drain_stalls <= 1'b1;
    foreach (RESET_PROBE[i]) send_sample(RESET_PROBE[i]);
    drain();

    // Directed: ignored indexes with both extreme patterns, then all coefficients
    // at their minimum
    write_reg(REG_SPARE_6, COEF_MAX);
    write_reg(REG_SPARE_7, COEF_MIN);
    load_coefs(SET_MIN);
    foreach (CLIP_PROBE[i]) send_sample(CLIP_PROBE[i]);
    drain();

    // Random phases, each under its own coefficient setting. One phase runs
    // without idling; the last one too.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == 3) || (p == RANDOM_PHASES - 1);
      feed_gaps = !quiet;
      drain_stalls <= !quiet;
      load_coefs(coef_set_t'(p % 6));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold-off mid-stream: sender waits for every result before going on
        if (p == 1 && i == PHASE_ITEMS / 2)
          drain();
        send_sample(pick_sample());
      end
      drain();
    end

    $display("%0d samples under %0d coefficient settings (extremes, reset, random, spare)",
             items_sent, settings_used);
    $display("%0d results compared, %0d with overflow set, %0d mismatches",
             tracker.checked, tracker.clipped, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("iir2_lookahead_fixed_filter_test OK");
    else
      $display("iir2_lookahead_fixed_filter_test NOT OK");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/iir2la_pkg.sv
design/iir2la_prod.sv
design/iir2_lookahead_fixed_filter.sv
design/iir2la_checker.sv
tb/iir2_lookahead_fixed_filter_test.sv
